### rtl/flp_pkg.sv
`default_nettype none
package flp_pkg;

  localparam int FLOWS      = 64;
  localparam int FLOW_W     = 6;
  localparam int CNT_W      = 24;
  localparam int WDROP_W    = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] FUNC_SENT = 2'd0;
  localparam logic [1:0] FUNC_DROP = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [2:0] REG_FLOW_COUNT = 3'd0;
  localparam logic [2:0] REG_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_WEIGHT     = 3'd2;
  localparam logic [2:0] REG_WINDOW     = 3'd3;
  localparam logic [2:0] REG_ED_ENABLE  = 3'd4;
  localparam logic [2:0] REG_MIN_SAMP   = 3'd5;

  typedef struct packed {
    logic [6:0]  flow_count;
    logic [15:0] threshold;
    logic [15:0] weight;
    logic [7:0]  window;
    logic        ed_enable;
    logic [7:0]  min_samples;
  } cfg_t;

  typedef struct packed {
    logic lat;
    logic rd_evt;
    logic rd_walk;
    logic snd_upd;
    logic drp_upd;
    logic div_tick;
    logic dec;
    logic mul;
    logic walk_wr;
    logic j_clr;
    logic j_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       vld;
    logic       busy;
    logic       j_last;
    logic       n_zero;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/flp_div.sv
`default_nettype none
module flp_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [flp_pkg::CNT_W-1:0] num,
  input  wire logic [flp_pkg::CNT_W-1:0] den,
  output logic                         busy,
  output logic [15:0]                  q
);
  import flp_pkg::*;

  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] den_r;
  logic [4:0]       cnt;
  logic [CNT_W:0]   r2;

  assign r2 = {rem[CNT_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      den_r <= den;
      rem   <= {1'b0, num};
      cnt   <= 5'd16;
      if (den == '0) begin
        q    <= '0;
        busy <= 1'b0;
      end else if (num >= den) begin
        q    <= 16'hFFFF;
        busy <= 1'b0;
      end else begin
        q    <= '0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (r2 >= {1'b0, den_r}) begin
        rem <= r2 - {1'b0, den_r};
        q   <= {q[14:0], 1'b1};
      end else begin
        rem <= r2;
        q   <= {q[14:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/flp_dp.sv
`default_nettype none
module flp_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire flp_pkg::cfg_t cfg,
  input  wire flp_pkg::cmd_t cmd,
  output flp_pkg::sts_t      sts,
  input  wire logic [7:0]    in_data,
  input  wire logic [2:0]    in_user,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [47:0]        out_data,
  output logic               out_last
);
  import flp_pkg::*;

  logic [CNT_W-1:0] rcv_mem [FLOWS];
  logic [CNT_W-1:0] drp_mem [FLOWS];
  logic [CNT_W-1:0] wa_mem  [FLOWS];
  logic [15:0]      sl_mem  [FLOWS];
  logic [FLOWS-1:0] rcv_vld, drp_vld, wa_vld, sl_vld;

  logic [1:0]        func_r;
  logic              vld_r;
  logic [FLOW_W-1:0] idx;
  logic [FLOW_W-1:0] j;
  logic [CNT_W-1:0]  rcv_q, drp_q, wa_q, rcv_new;
  logic [15:0]       sl_q;
  logic [7:0]        wpk;
  logic signed [WDROP_W-1:0] wdr;
  logic [15:0]       short_loss;
  logic              close_r;
  logic [31:0]       p1;
  logic [32:0]       p2;

  logic [FLOW_W-1:0] ra, wa_addr;
  logic [7:0]        wpk_inc;
  logic              close_now;
  logic              div_start, div_busy;
  logic [CNT_W-1:0]  div_num, div_den;
  logic [15:0]       dq, sl_eff;
  logic              mark;
  logic [6:0]        n;
  logic [33:0]       sum;
  logic [17:0]       nl_w;
  logic [15:0]       nl;
  logic [CNT_W-1:0]  allow;
  logic              out_free;

  assign ra       = cmd.rd_walk ? j : idx;
  assign wa_addr  = cmd.walk_wr ? j : idx;
  assign wpk_inc  = wpk + 8'd1;
  assign close_now = (cfg.window != 8'd0) && (wpk_inc == cfg.window);
  assign div_start = (cmd.snd_upd && close_now) || cmd.div_tick;
  assign div_num = cmd.div_tick ? drp_q :
                   ((wdr > 0) ? CNT_W'(unsigned'(wdr)) : '0);
  assign div_den = cmd.div_tick ? rcv_q : CNT_W'(wpk_inc);
  assign sl_eff  = close_r ? dq : short_loss;
  assign mark = vld_r && cfg.ed_enable && (rcv_new > wa_q) &&
                ((sl_eff > cfg.threshold) || (sl_q > cfg.threshold));
  assign n      = (cfg.flow_count > 7'(FLOWS)) ? 7'(FLOWS) : cfg.flow_count;
  assign sum    = {2'b0, p1} + {1'b0, p2} + 34'd32768;
  assign nl_w   = sum[33:16];
  assign nl     = (nl_w > 18'hFFFF) ? 16'hFFFF : nl_w[15:0];
  assign allow  = (rcv_q >= drp_q) ? rcv_q - drp_q : '0;
  assign out_free = !out_valid || out_ready;

  assign sts.func     = func_r;
  assign sts.vld      = vld_r;
  assign sts.busy     = div_busy;
  assign sts.j_last   = ({1'b0, j} + 7'd1) == n;
  assign sts.n_zero   = cfg.flow_count == 7'd0;
  assign sts.out_free = out_free;

  flp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .q(dq)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_evt || cmd.rd_walk) begin
      rcv_q <= rcv_vld[ra] ? rcv_mem[ra] : '0;
      drp_q <= drp_vld[ra] ? drp_mem[ra] : '0;
      wa_q  <= wa_vld[ra]  ? wa_mem[ra]  : '0;
      sl_q  <= sl_vld[ra]  ? sl_mem[ra]  : '0;
    end
    if (cmd.snd_upd) begin
      rcv_mem[wa_addr] <= (rcv_q == CNT_MAX) ? CNT_MAX : rcv_q + CNT_W'(1);
      rcv_new          <= (rcv_q == CNT_MAX) ? CNT_MAX : rcv_q + CNT_W'(1);
    end
    if (cmd.drp_upd) begin
      drp_mem[wa_addr] <= (drp_q == CNT_MAX) ? CNT_MAX : drp_q + CNT_W'(1);
    end
    if (cmd.walk_wr) begin
      rcv_mem[wa_addr] <= '0;
      drp_mem[wa_addr] <= '0;
      wa_mem[wa_addr]  <= allow;
      sl_mem[wa_addr]  <= nl;
    end
    if (cmd.mul) begin
      p1 <= cfg.weight * sl_q;
      p2 <= (rcv_q > CNT_W'(cfg.min_samples)) ? (17'h10000 - {1'b0, cfg.weight}) * dq : '0;
    end
    if (cmd.lat) begin
      idx    <= in_data[FLOW_W-1:0];
      func_r <= in_user[1:0];
      vld_r  <= in_user[2] && ({1'b0, in_data[FLOW_W-1:0]} < 7'(FLOWS));
    end
    if (cmd.dec || cmd.walk_wr) begin
      out_last <= cmd.dec || sts.j_last;
      out_data <= cmd.dec ? {47'b0, mark} :
                  {1'b0, nl, allow, j, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcv_vld    <= '0;
      drp_vld    <= '0;
      wa_vld     <= '0;
      sl_vld     <= '0;
      wpk        <= '0;
      wdr        <= '0;
      short_loss <= '0;
      close_r    <= 1'b0;
      j          <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.lat) begin
        close_r <= 1'b0;
        if (in_user[1:0] == FUNC_DROP && wdr != 10'sd511) wdr <= wdr + 10'sd1;
      end
      if (cmd.snd_upd) begin
        rcv_vld[wa_addr] <= 1'b1;
        close_r <= close_now;
        if (close_now) begin
          wpk <= '0;
          wdr <= '0;
        end else begin
          wpk <= wpk_inc;
        end
      end
      if (cmd.drp_upd) drp_vld[wa_addr] <= 1'b1;
      if (cmd.walk_wr) begin
        rcv_vld[wa_addr] <= 1'b1;
        drp_vld[wa_addr] <= 1'b1;
        wa_vld[wa_addr]  <= 1'b1;
        sl_vld[wa_addr]  <= 1'b1;
      end
      if (cmd.dec) begin
        if (close_r) short_loss <= dq;
        if (mark && wdr != -10'sd512) wdr <= wdr - 10'sd1;
      end
      if (cmd.j_clr) j <= '0;
      else if (cmd.j_inc) j <= j + FLOW_W'(1);
      if (cmd.dec || cmd.walk_wr) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/flp_ctrl.sv
`default_nettype none
module flp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire flp_pkg::sts_t sts,
  output flp_pkg::cmd_t      cmd
);
  import flp_pkg::*;

  typedef enum logic [12:0] {
    IDLE   = 13'b0000000000001,
    DISP   = 13'b0000000000010,
    S_RD   = 13'b0000000000100,
    S_UPD  = 13'b0000000001000,
    S_DIVW = 13'b0000000010000,
    S_DEC  = 13'b0000000100000,
    D_RD   = 13'b0000001000000,
    D_UPD  = 13'b0000010000000,
    W_RD   = 13'b0000100000000,
    W_DIV  = 13'b0001000000000,
    W_WAIT = 13'b0010000000000,
    W_MUL  = 13'b0100000000000,
    W_WR   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      IDLE: if (in_valid) begin
        cmd.lat = 1'b1;
        state_next = DISP;
      end
      DISP: begin
        case (sts.func)
          FUNC_SENT: state_next = sts.vld ? S_RD : S_DEC;
          FUNC_DROP: state_next = sts.vld ? D_RD : IDLE;
          FUNC_TICK: begin
            if (sts.n_zero) state_next = IDLE;
            else begin
              cmd.j_clr = 1'b1;
              state_next = W_RD;
            end
          end
          default: state_next = IDLE;
        endcase
      end
      S_RD: begin
        cmd.rd_evt = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.snd_upd = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: if (!sts.busy) state_next = S_DEC;
      S_DEC: if (sts.out_free) begin
        cmd.dec = 1'b1;
        state_next = IDLE;
      end
      D_RD: begin
        cmd.rd_evt = 1'b1;
        state_next = D_UPD;
      end
      D_UPD: begin
        cmd.drp_upd = 1'b1;
        state_next = IDLE;
      end
      W_RD: begin
        cmd.rd_walk = 1'b1;
        state_next = W_DIV;
      end
      W_DIV: begin
        cmd.div_tick = 1'b1;
        state_next = W_WAIT;
      end
      W_WAIT: if (!sts.busy) state_next = W_MUL;
      W_MUL: begin
        cmd.mul = 1'b1;
        state_next = W_WR;
      end
      W_WR: if (sts.out_free) begin
        cmd.walk_wr = 1'b1;
        if (sts.j_last) state_next = IDLE;
        else begin
          cmd.j_inc = 1'b1;
          state_next = W_RD;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

### rtl/per_flow_loss_policer_core.sv
`default_nettype none
// Sent packet: tagged ones update the flow, then use the shared 16-step divider
// when the window closes with a ratio below one. Dropped packet: tagged ones
// update their count. Period tick: walks the flows, using the divider where a
// ratio needs it. Output stalls hold sends and ticks; one request at a time.
// Reset (rst, synchronous): config to defaults, per-flow valid bits cleared so
// all tables read as zero at once; no clearing pass.
module per_flow_loss_policer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // flow_id[5:0]
  input  wire logic [2:0]  s_tuser,  // func[1:0], has_tag[2]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // early_drop, flow_index, allowance, loss_rate
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import flp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_count  <= 7'd8;
      cfg.threshold   <= 16'd3277;
      cfg.weight      <= 16'd52429;
      cfg.window      <= 8'd50;
      cfg.ed_enable   <= 1'b1;
      cfg.min_samples <= 8'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FLOW_COUNT: cfg.flow_count  <= cfg_data[6:0];
        REG_THRESHOLD:  cfg.threshold   <= cfg_data;
        REG_WEIGHT:     cfg.weight      <= cfg_data;
        REG_WINDOW:     cfg.window      <= cfg_data[7:0];
        REG_ED_ENABLE:  cfg.ed_enable   <= cfg_data[0];
        REG_MIN_SAMP:   cfg.min_samples <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  flp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  flp_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .sts(sts),
    .in_data(s_tdata), .in_user(s_tuser),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata), .out_last(m_tlast)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted back to back");
  a_mark_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[46:1] == 46'd0 && m_tlast)
    else $error("early drop result carries tick fields");
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.snd_upd, cmd.drp_upd, cmd.walk_wr, cmd.dec}))
    else $error("conflicting table commands");
endmodule
`default_nettype wire

### tb/per_flow_loss_policer_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none

class policer_scoreboard;
  logic [6:0]  flow_count;
  logic [15:0] threshold;
  logic [15:0] weight;
  logic [7:0]  window;
  logic        ed_enable;
  logic [7:0]  min_samples;
  logic [23:0] rcv_cnt [64];
  logic [23:0] drp_cnt [64];
  logic [23:0] allow_cnt [64];
  logic [15:0] smooth [64];
  logic [7:0]  win_pkts;
  int          win_drops;
  logic [15:0] short_loss;
  logic [47:0] exp_data [$];
  logic        exp_last [$];
  int          errors;

  function new();
    flow_count = 8;
    threshold = 3277;
    weight = 52429;
    window = 50;
    ed_enable = 1;
    min_samples = 5;
    for (int i = 0; i < 64; i++) begin
      rcv_cnt[i] = 0;
      drp_cnt[i] = 0;
      allow_cnt[i] = 0;
      smooth[i] = 0;
    end
    win_pkts = 0;
    win_drops = 0;
    short_loss = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      flp_pkg::REG_FLOW_COUNT: flow_count = val[6:0];
      flp_pkg::REG_THRESHOLD:  threshold = val;
      flp_pkg::REG_WEIGHT:     weight = val;
      flp_pkg::REG_WINDOW:     window = val[7:0];
      flp_pkg::REG_ED_ENABLE:  ed_enable = val[0];
      flp_pkg::REG_MIN_SAMP:   min_samples = val[7:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return 0;
    q = (num << 16) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function void note_request(logic [1:0] func, logic tag, logic [5:0] fid);
    logic mark;
    int n;
    longint unsigned sum, lo, nl, al;
    case (func)
      flp_pkg::FUNC_SENT: begin
        mark = 0;
        if (tag) begin
          if (rcv_cnt[fid] != flp_pkg::CNT_MAX) rcv_cnt[fid]++;
          win_pkts++;
          if (window != 0 && win_pkts == window) begin
            short_loss = ratio(win_drops > 0 ? win_drops : 0, win_pkts);
            win_pkts = 0;
            win_drops = 0;
          end
          if (ed_enable && rcv_cnt[fid] > allow_cnt[fid] &&
              (short_loss > threshold || smooth[fid] > threshold)) begin
            mark = 1;
            if (win_drops > -512) win_drops--;
          end
        end
        exp_data.push_back({47'd0, mark});
        exp_last.push_back(1'b1);
      end
      flp_pkg::FUNC_DROP: begin
        if (win_drops < 511) win_drops++;
        if (tag && drp_cnt[fid] != flp_pkg::CNT_MAX) drp_cnt[fid]++;
      end
      flp_pkg::FUNC_TICK: begin
        n = (flow_count > 64) ? 64 : flow_count;
        for (int j = 0; j < n; j++) begin
          lo = ratio(drp_cnt[j], rcv_cnt[j]);
          sum = longint'(weight) * smooth[j];
          if (rcv_cnt[j] > min_samples) sum += (65536 - longint'(weight)) * lo;
          nl = (sum + 32768) >> 16;
          if (nl > 65535) nl = 65535;
          smooth[j] = nl[15:0];
          al = (rcv_cnt[j] >= drp_cnt[j]) ? rcv_cnt[j] - drp_cnt[j] : 0;
          allow_cnt[j] = al[23:0];
          exp_data.push_back({1'b0, nl[15:0], al[23:0], 6'(j), 1'b0});
          exp_last.push_back(j == n - 1);
        end
        for (int j = 0; j < n; j++) begin
          rcv_cnt[j] = 0;
          drp_cnt[j] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [47:0] data, logic lst);
    if (exp_data.size() == 0) begin
      $display("%0t unexpected result data=%h last=%b", $time, data, lst);
      errors++;
      return;
    end
    if (data[47] !== exp_data[0][47] || data[46:41] !== exp_data[0][46:41] ||
        data[40:16] !== exp_data[0][40:16] || data[15:0] !== exp_data[0][15:0] ||
        lst !== exp_last[0]) begin
      $display("%0t mismatch: expected data=%h last=%b actual data=%h last=%b",
               $time, exp_data[0], exp_last[0], data, lst);
      errors++;
    end
    void'(exp_data.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module per_flow_loss_policer_core_tb;
  import flp_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic [2:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  policer_scoreboard flow_sb = new();
  bit long_hold = 0;

  per_flow_loss_policer_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  int gap_mode = 0;

  function int draw_gap();
    return (gap_mode == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  task send_request(logic [1:0] func, logic tag, logic [5:0] fid);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= {tag, func};
    s_tdata <= {2'b00, fid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    flow_sb.note_request(func, tag, fid);
    @(negedge clk);
  endtask

  task end_send();
    s_tvalid <= 0;
    @(negedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [15:0] val);
    end_send();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    flow_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task drain();
    end_send();
    while (flow_sb.exp_data.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task random_burst(int count, int fid_max);
    logic [1:0] f;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      f = (r < 55) ? FUNC_SENT : (r < 92) ? FUNC_DROP : (r < 98) ? FUNC_TICK : FUNC_NONE;
      send_request(f, $urandom_range(0, 9) != 0, 6'($urandom_range(0, fid_max)));
    end
  endtask

  // output side
  initial begin
    int hold;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      hold = draw_gap();
      if (hold != 0) begin
        m_tready <= 0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) flow_sb.check_result(m_tdata, m_tlast);
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed
    send_request(FUNC_SENT, 1, 0);
    send_request(FUNC_SENT, 1, 63);
    send_request(FUNC_SENT, 0, 5);
    send_request(FUNC_DROP, 1, 0);
    send_request(FUNC_DROP, 0, 63);
    send_request(FUNC_NONE, 1, 42);
    for (int k = 0; k < 8; k++) send_request(FUNC_SENT, 1, 1);
    send_request(FUNC_DROP, 1, 1);
    send_request(FUNC_DROP, 1, 1);
    send_request(FUNC_TICK, 1, 21);
    send_request(FUNC_SENT, 1, 1);
    drain();

    write_reg(REG_FLOW_COUNT, 0);
    write_reg(REG_MIN_SAMP, 0);
    send_request(FUNC_TICK, 0, 0);
    send_request(FUNC_SENT, 1, 2);
    drain();

    // heavy-loss phase: small window, low threshold
    write_reg(REG_FLOW_COUNT, 4);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WEIGHT, 0);
    write_reg(REG_WINDOW, 1);
    write_reg(REG_ED_ENABLE, 1);
    gap_mode = 1;
    random_burst(60, 3);
    send_request(FUNC_TICK, 1, 0);
    drain();

    write_reg(REG_FLOW_COUNT, 64);
    write_reg(REG_THRESHOLD, 65535);
    write_reg(REG_WEIGHT, 65535);
    write_reg(REG_WINDOW, 255);
    write_reg(REG_MIN_SAMP, 255);
    random_burst(40, 63);
    send_request(FUNC_TICK, 0, 0);
    // stall output while sender keeps offering
    long_hold = 1;
    gap_mode = 0;
    for (int k = 0; k < 10; k++) send_request(FUNC_SENT, 1, k[5:0]);
    gap_mode = 1;
    drain();

    write_reg(REG_FLOW_COUNT, 8);
    write_reg(REG_THRESHOLD, 3277);
    write_reg(REG_WEIGHT, 52429);
    write_reg(REG_WINDOW, 0);
    write_reg(REG_ED_ENABLE, 0);
    write_reg(REG_MIN_SAMP, 5);
    random_burst(50, 7);
    drain();

    write_reg(REG_WINDOW, 7);
    write_reg(REG_ED_ENABLE, 1);
    write_reg(REG_THRESHOLD, 2000);
    write_reg(REG_FLOW_COUNT, 1);
    gap_mode = 0;
    random_burst(40, 63);
    gap_mode = 1;
    drain();
    write_reg(REG_FLOW_COUNT, 16);
    random_burst(80, 15);
    drain();

    if (flow_sb.errors == 0 && flow_sb.exp_data.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

### tb/per_flow_loss_policer_core_tb_notes.sv
`timescale 1ns / 100ps
